>>> rtl/core/ckcb_pkg.sv
// Shared types and constants for the color keyed clipped blit engine.
// Item structs, register file layout and status/opcode names. No dependencies.
`default_nettype none

package ckcb_pkg;

   localparam int ADDR_BITS    = 20;
   localparam int COORD_BITS   = 16;
   localparam int CFG_BITS     = 10;
   localparam int COLOR_BITS   = 24;
   localparam int CSR_IDX_BITS = 3;
   localparam int EXT_BITS     = COORD_BITS + 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_X      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_Y      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCE_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLOR_KEY     = 3'd5;

   localparam logic [CFG_BITS-1:0]   RST_CLIP_WIDTH    = 10'd320;
   localparam logic [CFG_BITS-1:0]   RST_CLIP_HEIGHT   = 10'd240;
   localparam logic [CFG_BITS-1:0]   RST_SOURCE_HEIGHT = 10'd240;
   localparam logic [COLOR_BITS-1:0] RST_COLOR_KEY     = 24'hFF00FF;

   localparam logic OP_START = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_IDLE  = 2'd2
   } status_type;

   typedef struct packed {
      logic                          op;
      logic signed [COORD_BITS-1:0]  dest_x;
      logic signed [COORD_BITS-1:0]  dest_y;
      logic signed [COORD_BITS-1:0]  crop_x;
      logic signed [COORD_BITS-1:0]  crop_y;
      logic signed [COORD_BITS-1:0]  crop_w;
      logic signed [COORD_BITS-1:0]  crop_h;
      logic [COLOR_BITS-1:0]         src_pixel;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic                   write_enable;
      logic [ADDR_BITS-1:0]   dst_addr;
      logic [COLOR_BITS-1:0]  pixel_out;
      logic [ADDR_BITS-1:0]   next_src_addr;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0]   clip_width;
      logic [CFG_BITS-1:0]   clip_height;
      logic [CFG_BITS-1:0]   origin_x;
      logic [CFG_BITS-1:0]   origin_y;
      logic [CFG_BITS-1:0]   source_height;
      logic [COLOR_BITS-1:0] color_key;
   } cfg_type;

   // Outcome of clipping a start item
   typedef struct packed {
      logic                 ok;
      logic [CFG_BITS-1:0]  width;
      logic [CFG_BITS-1:0]  height;
      logic [ADDR_BITS-1:0] dst;
      logic [ADDR_BITS-1:0] src;
   } clip_type;

endpackage

`default_nettype wire

>>> rtl/core/ckcb_clip.sv
// Start item clipping: reject, edge clip, origin add and first pixel indices.
// Purely combinational; uses ckcb_pkg.
`default_nettype none

module ckcb_clip (
   input  var ckcb_pkg::req_type  item,
   input  var ckcb_pkg::cfg_type  cfg,
   output ckcb_pkg::clip_type     clip
);

   localparam int EB = ckcb_pkg::EXT_BITS;
   localparam int CB = ckcb_pkg::COORD_BITS;
   localparam int FB = ckcb_pkg::CFG_BITS;
   localparam int AB = ckcb_pkg::ADDR_BITS;

   logic signed [EB-1:0] x_e, y_e, cx_e, cy_e, w_e, h_e;
   logic signed [EB-1:0] cw_e, ch_e;
   logic signed [EB-1:0] sum_xw, sum_yh;
   logic                 reject;
   logic signed [CB-1:0] cx1, cy1, w1, h1, w2, h2;
   logic signed [EB-1:0] x1, y1, w1_e, h1_e, end_x, end_y;
   logic                 empty;
   logic [FB:0]          x_fin, y_fin;
   logic [AB-1:0]        ch_a, sh_a, h_a, cx_a, cy_a, dst_mul, src_mul;

   assign x_e  = EB'(item.dest_x);
   assign y_e  = EB'(item.dest_y);
   assign cx_e = EB'(item.crop_x);
   assign cy_e = EB'(item.crop_y);
   assign w_e  = EB'(item.crop_w);
   assign h_e  = EB'(item.crop_h);
   assign cw_e = $signed({{(EB-FB){1'b0}}, cfg.clip_width});
   assign ch_e = $signed({{(EB-FB){1'b0}}, cfg.clip_height});

   assign sum_xw = x_e + w_e;
   assign sum_yh = y_e + h_e;
   assign reject = (x_e > cw_e) || (y_e > ch_e) || sum_xw[EB-1] || sum_yh[EB-1];

   // Clip left and top edges; stored coordinates wrap to the coordinate width
   always_comb begin
      if (x_e[EB-1]) begin
         cx1 = CB'(cx_e - x_e);
         w1  = CB'(sum_xw);
         x1  = '0;
      end else begin
         cx1 = item.crop_x;
         w1  = item.crop_w;
         x1  = x_e;
      end
      if (y_e[EB-1]) begin
         cy1 = CB'(cy_e - y_e);
         h1  = CB'(sum_yh);
         y1  = '0;
      end else begin
         cy1 = item.crop_y;
         h1  = item.crop_h;
         y1  = y_e;
      end
   end

   // Clip right and bottom edges
   assign w1_e  = EB'(w1);
   assign h1_e  = EB'(h1);
   assign end_x = x1 + w1_e;
   assign end_y = y1 + h1_e;
   assign w2    = (end_x > cw_e) ? CB'(cw_e - x1) : w1;
   assign h2    = (end_y > ch_e) ? CB'(ch_e - y1) : h1;
   assign empty = w2[CB-1] || (w2 == '0) || h2[CB-1] || (h2 == '0);

   assign x_fin = {1'b0, x1[FB-1:0]} + {1'b0, cfg.origin_x};
   assign y_fin = {1'b0, y1[FB-1:0]} + {1'b0, cfg.origin_y};

   // Destination is column-major and flipped: column stride is the clip height
   assign ch_a    = AB'(cfg.clip_height);
   assign sh_a    = AB'(cfg.source_height);
   assign h_a     = AB'(h2[FB-1:0]);
   assign cx_a    = AB'(cx1);
   assign cy_a    = AB'(cy1);
   assign dst_mul = AB'(x_fin) * ch_a;
   assign src_mul = sh_a * cx_a;

   always_comb begin
      clip.ok     = !reject && !empty;
      clip.width  = w2[FB-1:0];
      clip.height = h2[FB-1:0];
      clip.dst    = ch_a - h_a - AB'(y_fin) + dst_mul;
      clip.src    = sh_a - cy_a - h_a + src_mul;
   end

endmodule

`default_nettype wire

>>> rtl/core/ckcb_walker.sv
// Blit walker: busy flag, row/column counters and source/destination pointers.
// Builds the result for each item; uses ckcb_pkg and the clip result.
`default_nettype none

module ckcb_walker (
   input  var logic               clock,
   input  var logic               reset,
   input  var logic               step,
   input  var ckcb_pkg::req_type  item,
   input  var ckcb_pkg::cfg_type  cfg,
   input  var ckcb_pkg::clip_type clip,
   output ckcb_pkg::rsp_type      rsp
);

   localparam int FB = ckcb_pkg::CFG_BITS;
   localparam int AB = ckcb_pkg::ADDR_BITS;

   logic          busy_ff, busy_in;
   logic [FB-1:0] col_count_ff, col_count_in;
   logic [FB-1:0] row_count_ff, row_count_in;
   logic [FB-1:0] width_ff, width_in;
   logic [FB-1:0] height_ff, height_in;
   logic [AB-1:0] dest_ptr_ff, dest_ptr_in;
   logic [AB-1:0] src_ptr_ff, src_ptr_in;

   logic [FB-1:0] row_inc, col_inc;
   logic [AB-1:0] dest_inc, src_inc;

   assign row_inc  = row_count_ff + 1'b1;
   assign col_inc  = col_count_ff + 1'b1;
   assign dest_inc = dest_ptr_ff + 1'b1;
   assign src_inc  = src_ptr_ff + 1'b1;

   always_comb begin
      busy_in      = busy_ff;
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      dest_ptr_in  = dest_ptr_ff;
      src_ptr_in   = src_ptr_ff;
      rsp          = '0;
      if (step) begin
         if (item.op == ckcb_pkg::OP_START) begin
            // A start abandons any blit in progress
            busy_in = clip.ok;
            if (clip.ok) begin
               col_count_in      = '0;
               row_count_in      = '0;
               width_in          = clip.width;
               height_in         = clip.height;
               dest_ptr_in       = clip.dst;
               src_ptr_in        = clip.src;
               rsp.status        = ckcb_pkg::STATUS_OK;
               rsp.dst_addr      = clip.dst;
               rsp.next_src_addr = clip.src;
            end else begin
               rsp.status = ckcb_pkg::STATUS_EMPTY;
            end
         end else if (!busy_ff) begin
            rsp.status = ckcb_pkg::STATUS_IDLE;
         end else begin
            rsp.status       = ckcb_pkg::STATUS_OK;
            rsp.write_enable = (item.src_pixel != cfg.color_key);
            rsp.dst_addr     = dest_ptr_ff;
            rsp.pixel_out    = item.src_pixel;
            row_count_in     = row_inc;
            dest_ptr_in      = dest_inc;
            src_ptr_in       = src_inc;
            if (row_inc >= height_ff) begin
               // Column done: skip the rest of both column strides
               row_count_in = '0;
               col_count_in = col_inc;
               dest_ptr_in  = dest_inc + AB'(cfg.clip_height) - AB'(height_ff);
               src_ptr_in   = src_inc + AB'(cfg.source_height) - AB'(height_ff);
            end
            if (row_inc >= height_ff && col_inc >= width_ff) begin
               busy_in  = 1'b0;
               rsp.last = 1'b1;
            end else begin
               rsp.next_src_addr = src_ptr_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         col_count_ff <= '0;
         row_count_ff <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         dest_ptr_ff  <= '0;
         src_ptr_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         dest_ptr_ff  <= dest_ptr_in;
         src_ptr_ff   <= src_ptr_in;
      end
   end

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (row_count_ff < height_ff))
      else $error("row counter beyond clipped height");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (col_count_ff < width_ff))
      else $error("column counter beyond clipped width");

   a_last_ends_blit: assert property (@(posedge clock) disable iff (reset)
      (step && rsp.last) |-> busy_ff ##1 !busy_ff)
      else $error("last pixel did not end the blit");

   a_idle_pixel: assert property (@(posedge clock) disable iff (reset)
      (step && item.op == ckcb_pkg::OP_PIXEL && !busy_ff) |=> !busy_ff)
      else $error("pixel item while idle changed busy");

endmodule

`default_nettype wire

>>> rtl/core/color_keyed_clipped_blit.sv
// Color keyed clipped blit address engine, top level.
// Item path: input register, then result register; clip, address multiply and pointer
// step sit in one stage between them. One item per cycle unless rsp_stall blocks results.
// Reset (synchronous) empties both registers, goes idle and loads the default registers.
// Depends on ckcb_pkg, ckcb_clip and ckcb_walker.
`default_nettype none

module color_keyed_clipped_blit (
   input  var logic                                   clock,
   input  var logic                                   reset,
   input  var logic                                   req_valid,
   output logic                                       req_stall,
   input  var ckcb_pkg::req_type                      req_item,
   output logic                                       rsp_valid,
   input  var logic                                   rsp_stall,
   output ckcb_pkg::rsp_type                          rsp_item,
   input  var logic                                   csr_we,
   input  var logic [ckcb_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  var logic [ckcb_pkg::COLOR_BITS-1:0]        csr_wdata
);

   localparam int FB = ckcb_pkg::CFG_BITS;

   logic               in_valid_ff, in_valid_in;
   ckcb_pkg::req_type  in_item_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   ckcb_pkg::rsp_type  rsp_item_ff;
   ckcb_pkg::cfg_type  cfg_ff, cfg_in;
   ckcb_pkg::clip_type clip;
   ckcb_pkg::rsp_type  rsp_next;
   logic               advance, req_take;

   // Advance a held item when the result register is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ckcb_pkg::CSR_CLIP_WIDTH:    cfg_in.clip_width    = csr_wdata[FB-1:0];
            ckcb_pkg::CSR_CLIP_HEIGHT:   cfg_in.clip_height   = csr_wdata[FB-1:0];
            ckcb_pkg::CSR_ORIGIN_X:      cfg_in.origin_x      = csr_wdata[FB-1:0];
            ckcb_pkg::CSR_ORIGIN_Y:      cfg_in.origin_y      = csr_wdata[FB-1:0];
            ckcb_pkg::CSR_SOURCE_HEIGHT: cfg_in.source_height = csr_wdata[FB-1:0];
            ckcb_pkg::CSR_COLOR_KEY:     cfg_in.color_key     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ckcb_clip u_clip (
      .item (in_item_ff),
      .cfg  (cfg_ff),
      .clip (clip)
   );

   ckcb_walker u_walker (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .clip  (clip),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         cfg_ff.clip_width      <= ckcb_pkg::RST_CLIP_WIDTH;
         cfg_ff.clip_height     <= ckcb_pkg::RST_CLIP_HEIGHT;
         cfg_ff.origin_x        <= '0;
         cfg_ff.origin_y        <= '0;
         cfg_ff.source_height   <= ckcb_pkg::RST_SOURCE_HEIGHT;
         cfg_ff.color_key       <= ckcb_pkg::RST_COLOR_KEY;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers hold while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach the result register");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked item");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("waiting item dropped from input register");

endmodule

`default_nettype wire
